>>> hw/rtl/mbusb_pkg.sv
// ----------------------------------------------------------------------------
// mbusb_pkg
// Shared types and constants for the serial MIDI to USB-MIDI packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mbusb_pkg;

  // Parser phase; unused codes behave as idle.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DATA2 = 3'd1,
    PH_DATA3 = 3'd2,
    PH_SX1   = 3'd3,
    PH_SX2   = 3'd4,
    PH_SX3   = 3'd5
  } phase_e;

  // MIDI status bytes
  localparam logic [7:0] StSysexStart = 8'hF0;
  localparam logic [7:0] StMtcQuarter = 8'hF1;
  localparam logic [7:0] StSongPos    = 8'hF2;
  localparam logic [7:0] StSongSel    = 8'hF3;
  localparam logic [7:0] StUndefF4    = 8'hF4;
  localparam logic [7:0] StUndefF5    = 8'hF5;
  localparam logic [7:0] StTuneReq    = 8'hF6;
  localparam logic [7:0] StSysexEnd   = 8'hF7;
  localparam logic [7:0] ByteZero     = 8'h00;

  // Code index numbers
  localparam logic [3:0] CinSysCom2  = 4'h2;
  localparam logic [3:0] CinSysCom3  = 4'h3;
  localparam logic [3:0] CinSysexCon = 4'h4;
  localparam logic [3:0] CinEnd1     = 4'h5;
  localparam logic [3:0] CinEnd2     = 4'h6;
  localparam logic [3:0] CinEnd3     = 4'h7;
  localparam logic [3:0] CinSingle   = 4'hF;

  // Data byte count of a channel voice status: program change and
  // channel pressure take one, the rest two.
  function automatic logic [1:0] voice_count(input logic [7:0] status);
    voice_count = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 2'd1 : 2'd2;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/midi_byte_to_usb_midi_packet.sv
// ----------------------------------------------------------------------------
// midi_byte_to_usb_midi_packet
// Serial MIDI byte stream to four-byte USB-MIDI event packets.
// ----------------------------------------------------------------------------
// Input channel: one received MIDI byte per beat (in_valid_i / in_stall_o).
// Output channel: one packet per beat (out_valid_o / out_stall_i): header
// with cable number and CIN, then three MIDI bytes, zero padded.
// Not every byte makes a packet: status and leading data bytes are held
// until the message (or three SysEx bytes) is complete. Real-time bytes
// F8..FF pass straight out as single-byte packets at any point.
// A packet appears in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while the input is not stalled; the parse
// state and the packet register are updated in the same cycle the byte is taken.
// The single packet register frees up in the cycle it is taken, so input
// is only held off while a packet sits stalled on the output.
// cfg_we_i writes the 4-bit cable number; write it only while idle.
// Reset clears the parse state, running status, cable number and the
// output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_to_usb_midi_packet (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] packet_header_o,
  output logic      [7:0] packet_byte1_o,
  output logic      [7:0] packet_byte2_o,
  output logic      [7:0] packet_byte3_o
);

  mbusb_pkg::phase_e phase_q, phase_d;
  logic [3:0] cable_q;
  logic [3:0] held_cin_q, held_cin_d;
  logic [7:0] held_status_q, held_status_d;
  logic [1:0] data_needed_q, data_needed_d;
  logic [7:0] part1_q, part1_d;
  logic [7:0] part2_q, part2_d;

  logic       out_valid_q;
  logic [7:0] hdr_q, b1_q, b2_q, b3_q;

  logic       in_acc;
  logic       emit;
  logic [3:0] emit_cin;
  logic [7:0] emit_b1, emit_b2, emit_b3;
  logic       in_sx, is_rt, is_status;
  logic       first_data;
  logic [3:0] f_cin;
  logic [7:0] f_p1;
  logic [1:0] f_dn;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_sx = (phase_q == mbusb_pkg::PH_SX1) || (phase_q == mbusb_pkg::PH_SX2) ||
                 (phase_q == mbusb_pkg::PH_SX3);
  assign is_rt = (rx_byte_i[7:3] == 5'b11111);
  assign is_status = rx_byte_i[7] && !((rx_byte_i == mbusb_pkg::StSysexEnd) && in_sx);

  always_comb begin
    phase_d       = phase_q;
    held_cin_d    = held_cin_q;
    held_status_d = held_status_q;
    data_needed_d = data_needed_q;
    part1_d       = part1_q;
    part2_d       = part2_q;
    emit          = 1'b0;
    emit_cin      = mbusb_pkg::CinSingle;
    emit_b1       = rx_byte_i;
    emit_b2       = mbusb_pkg::ByteZero;
    emit_b3       = mbusb_pkg::ByteZero;
    first_data    = 1'b0;
    f_cin         = held_cin_q;
    f_p1          = part1_q;
    f_dn          = data_needed_q;

    if (in_acc) begin
      if (is_rt) begin
        emit = 1'b1;
      end else if (is_status) begin
        phase_d = mbusb_pkg::PH_IDLE;
        if (rx_byte_i == mbusb_pkg::StSysexStart) begin
          held_status_d = mbusb_pkg::ByteZero;
          part1_d       = rx_byte_i;
          phase_d       = mbusb_pkg::PH_SX2;
        end else if (rx_byte_i[7:4] != 4'hF) begin
          held_status_d = rx_byte_i;
          held_cin_d    = rx_byte_i[7:4];
          data_needed_d = mbusb_pkg::voice_count(rx_byte_i);
          part1_d       = rx_byte_i;
          phase_d       = mbusb_pkg::PH_DATA2;
        end else begin
          held_status_d = mbusb_pkg::ByteZero;
          case (rx_byte_i)
            mbusb_pkg::StMtcQuarter, mbusb_pkg::StSongSel: begin
              held_cin_d    = mbusb_pkg::CinSysCom2;
              data_needed_d = 2'd1;
              part1_d       = rx_byte_i;
              phase_d       = mbusb_pkg::PH_DATA2;
            end
            mbusb_pkg::StSongPos: begin
              held_cin_d    = mbusb_pkg::CinSysCom3;
              data_needed_d = 2'd2;
              part1_d       = rx_byte_i;
              phase_d       = mbusb_pkg::PH_DATA2;
            end
            mbusb_pkg::StUndefF4, mbusb_pkg::StUndefF5, mbusb_pkg::StTuneReq: begin
              emit     = 1'b1;
              emit_cin = mbusb_pkg::CinEnd1;
            end
            default: begin
              // stray end of SysEx
              emit = 1'b1;
            end
          endcase
        end
      end else begin
        // data byte, or F7 closing a SysEx
        case (phase_q)
          mbusb_pkg::PH_DATA2: begin
            first_data = 1'b1;
          end
          mbusb_pkg::PH_DATA3: begin
            phase_d  = mbusb_pkg::PH_IDLE;
            emit     = 1'b1;
            emit_cin = held_cin_q;
            emit_b1  = part1_q;
            emit_b2  = part2_q;
            emit_b3  = rx_byte_i;
          end
          mbusb_pkg::PH_SX1: begin
            if (rx_byte_i == mbusb_pkg::StSysexEnd) begin
              phase_d  = mbusb_pkg::PH_IDLE;
              emit     = 1'b1;
              emit_cin = mbusb_pkg::CinEnd1;
            end else begin
              part1_d = rx_byte_i;
              phase_d = mbusb_pkg::PH_SX2;
            end
          end
          mbusb_pkg::PH_SX2: begin
            if (rx_byte_i == mbusb_pkg::StSysexEnd) begin
              phase_d  = mbusb_pkg::PH_IDLE;
              emit     = 1'b1;
              emit_cin = mbusb_pkg::CinEnd2;
              emit_b1  = part1_q;
              emit_b2  = rx_byte_i;
            end else begin
              part2_d = rx_byte_i;
              phase_d = mbusb_pkg::PH_SX3;
            end
          end
          mbusb_pkg::PH_SX3: begin
            emit    = 1'b1;
            emit_b1 = part1_q;
            emit_b2 = part2_q;
            emit_b3 = rx_byte_i;
            if (rx_byte_i == mbusb_pkg::StSysexEnd) begin
              phase_d  = mbusb_pkg::PH_IDLE;
              emit_cin = mbusb_pkg::CinEnd3;
            end else begin
              phase_d  = mbusb_pkg::PH_SX1;
              emit_cin = mbusb_pkg::CinSysexCon;
            end
          end
          default: begin
            // idle: running status restarts a channel voice message
            phase_d = mbusb_pkg::PH_IDLE;
            if (held_status_q[7] && held_status_q[7:4] != 4'hF) begin
              first_data    = 1'b1;
              f_cin         = held_status_q[7:4];
              f_p1          = held_status_q;
              f_dn          = mbusb_pkg::voice_count(held_status_q);
              held_cin_d    = f_cin;
              part1_d       = f_p1;
              data_needed_d = f_dn;
            end
          end
        endcase

        if (first_data) begin
          if (f_dn < 2'd2) begin
            phase_d  = mbusb_pkg::PH_IDLE;
            emit     = 1'b1;
            emit_cin = f_cin;
            emit_b1  = f_p1;
            emit_b2  = rx_byte_i;
          end else begin
            part2_d = rx_byte_i;
            phase_d = mbusb_pkg::PH_DATA3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= mbusb_pkg::PH_IDLE;
      cable_q       <= 4'd0;
      held_cin_q    <= 4'd0;
      held_status_q <= 8'd0;
      data_needed_q <= 2'd0;
      part1_q       <= 8'd0;
      part2_q       <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      held_cin_q    <= held_cin_d;
      held_status_q <= held_status_d;
      data_needed_q <= data_needed_d;
      part1_q       <= part1_d;
      part2_q       <= part2_d;
      if (cfg_we_i) begin
        cable_q <= cfg_wdata_i;
      end
      if (in_acc && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      hdr_q <= {cable_q, emit_cin};
      b1_q  <= emit_b1;
      b2_q  <= emit_b2;
      b3_q  <= emit_b3;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_header_o = hdr_q;
  assign packet_byte1_o  = b1_q;
  assign packet_byte2_o  = b2_q;
  assign packet_byte3_o  = b3_q;

`ifndef SYNTHESIS
  // running status only ever holds a channel voice status
  a_status_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_status_q == 8'd0 || (held_status_q[7] && held_status_q[7:4] != 4'hF))
    else $error("running status holds a non-voice byte");

  // inside a SysEx there is no running status
  a_sysex_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sx |-> held_status_q == 8'd0)
    else $error("running status set during SysEx");

  // real-time beat goes out next cycle and leaves the parse phase alone
  a_realtime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_rt) |=> (out_valid_q && b1_q == $past(rx_byte_i) &&
      hdr_q[3:0] == mbusb_pkg::CinSingle && phase_q == $past(phase_q)))
    else $error("real-time byte mishandled");

  // input is only held off by a stalled packet
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no packet pending");
`endif

endmodule

`default_nettype wire
